@@ rtl/barometer_temp_pressure_compensation_unit_defines.svh @@
// Assertion helpers for the compensation unit RTL, used by the divider.
`ifndef BAROMETER_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETER_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BTPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a signal is unchanged in the cycle after a condition.
`define BTPC_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ rtl/btpc_pkg.sv @@
`default_nettype none
package btpc_pkg;

	localparam int unsigned DivBits = 32;

	// register indexes on the configuration port
	localparam logic [1:0] REG_TEMP_COEFFS  = 2'd0;
	localparam logic [1:0] REG_PRESS_A      = 2'd1;
	localparam logic [1:0] REG_PRESS_B      = 2'd2;
	localparam logic [1:0] REG_PRESS_LAST   = 2'd3;

	typedef struct packed {
		logic [47:0] temp_coeffs;
		logic [63:0] press_a;
		logic [63:0] press_b;
		logic [15:0] press_last;
	} cfg_t;

	// side information that rides along with the division
	typedef struct packed {
		logic [17:0] temp;
		logic        big;
		logic        zero;
	} tag_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
		asr = $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		sext16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] zext16(input logic [15:0] v);
		zext16 = {16'b0, v};
	endfunction

endpackage
`default_nettype wire

@@ rtl/barometer_temp_pressure_compensation_unit.sv @@
// Channel   Direction  Handshake                        Payload
// sample    in         sample_valid / sample_stall      raw_temperature, raw_pressure
// result    out        result_valid / result_stall      temperature_centi, pressure_pa,
//                                                       divisor_zero
// apb       in/out     psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One beat per cycle in and out unless a result beat is stalled; the pipeline has 3 temperature
// stages, 7 pressure stages, 32 divider stages and 4 correction stages incl. the output
// register. The 32-stage restoring divider, one quotient bit per stage, sets the depth.
// Reset clears all stage valid bits and the calibration registers.
// A stalled result beat freezes every stage, so the input is stalled in the same cycle.
`default_nettype none
module barometer_temp_pressure_compensation_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         sample_valid,
	output logic              sample_stall,
	input  wire logic [19:0]  raw_temperature,
	input  wire logic [19:0]  raw_pressure,
	output logic              result_valid,
	input  wire logic         result_stall,
	output logic signed [17:0] temperature_centi,
	output logic [31:0]       pressure_pa,
	output logic              divisor_zero,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import btpc_pkg::*;

	cfg_t        cfg_q;
	logic        adv, wr;
	logic        v_t, v_p, v_d;
	logic [31:0] fine, num, divisor, quot;
	logic [19:0] adc_p;
	tag_t        tag_p, tag_d;
	logic [17:0] temp;

	// the whole pipeline moves unless the result beat is held downstream
	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;
	assign pready       = 1'b1;
	assign wr           = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (paddr[4:3])
				REG_TEMP_COEFFS: cfg_q.temp_coeffs <= pwdata[47:0];
				REG_PRESS_A:     cfg_q.press_a     <= pwdata;
				REG_PRESS_B:     cfg_q.press_b     <= pwdata;
				REG_PRESS_LAST:  cfg_q.press_last  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_TEMP_COEFFS: prdata = {16'b0, cfg_q.temp_coeffs};
			REG_PRESS_A:     prdata = cfg_q.press_a;
			REG_PRESS_B:     prdata = cfg_q.press_b;
			REG_PRESS_LAST:  prdata = {48'b0, cfg_q.press_last};
			default:         prdata = '0;
		endcase
	end

	btpc_temp u_temp (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(sample_valid),
		.raw_t(raw_temperature), .raw_p(raw_pressure), .cfg(cfg_q),
		.v_out(v_t), .fine(fine), .adc_p(adc_p)
	);

	btpc_press u_press (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_t),
		.fine(fine), .adc_p(adc_p), .cfg(cfg_q),
		.v_out(v_p), .num(num), .divisor(divisor), .tag(tag_p)
	);

	btpc_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_p),
		.num(num), .divisor(divisor), .tag_in(tag_p),
		.v_out(v_d), .quot(quot), .tag_out(tag_d)
	);

	// last stage doubles as the output register
	btpc_corr u_corr (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_d),
		.quot(quot), .tag_in(tag_d), .cfg(cfg_q),
		.v_out(result_valid), .temp(temp), .press(pressure_pa), .zero(divisor_zero)
	);

	assign temperature_centi = $signed(temp);
endmodule
`default_nettype wire

@@ rtl/btpc_temp.sv @@
`default_nettype none
module btpc_temp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                v_in,
	input  wire logic [19:0]         raw_t,
	input  wire logic [19:0]         raw_p,
	input  wire btpc_pkg::cfg_t      cfg,
	output logic                     v_out,
	output logic [31:0]              fine,
	output logic [19:0]              adc_p
);
	import btpc_pkg::*;

	logic [31:0] t1, t2, t3, x, d;
	logic        v_s1, v_s2, v_s3;
	logic [31:0] ma_s1, dd_s1, a_s2, mb_s2, fine_s3;
	logic [19:0] p_s1, p_s2, p_s3;

	assign t1 = zext16(cfg.temp_coeffs[15:0]);
	assign t2 = sext16(cfg.temp_coeffs[31:16]);
	assign t3 = sext16(cfg.temp_coeffs[47:32]);
	assign x  = ({12'b0, raw_t} >> 3) - (t1 << 1);
	assign d  = ({12'b0, raw_t} >> 4) - t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1   <= x * t2;
			dd_s1   <= d * d;
			p_s1    <= raw_p;
			a_s2    <= asr(ma_s1, 5'd11);
			mb_s2   <= asr(dd_s1, 5'd12) * t3;
			p_s2    <= p_s1;
			fine_s3 <= a_s2 + asr(mb_s2, 5'd14);
			p_s3    <= p_s2;
		end
	end

	assign v_out = v_s3;
	assign fine  = fine_s3;
	assign adc_p = p_s3;
endmodule
`default_nettype wire

@@ rtl/btpc_press.sv @@
`default_nettype none
module btpc_press (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                v_in,
	input  wire logic [31:0]         fine,
	input  wire logic [19:0]         adc_p,
	input  wire btpc_pkg::cfg_t      cfg,
	output logic                     v_out,
	output logic [31:0]              num,
	output logic [31:0]              divisor,
	output btpc_pkg::tag_t           tag
);
	import btpc_pkg::*;

	logic [31:0] p1, p2, p3, p4, p5, p6, q, pn_pre;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [17:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [19:0] p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [31:0] a_s1, sq_s2, ap5_s2, p2a_s2, b1_s3, c3_s3, ap5_s3, p2a_s3;
	logic [31:0] b_s4, a2_s4, m_s5, b12_s5, div_s6, pn_s6, num_s7, div_s7;
	logic [31:0] tmp_c;
	logic        big_s7, zero_s7;

	assign p1 = zext16(cfg.press_a[15:0]);
	assign p2 = sext16(cfg.press_a[31:16]);
	assign p3 = sext16(cfg.press_a[47:32]);
	assign p4 = sext16(cfg.press_a[63:48]);
	assign p5 = sext16(cfg.press_b[15:0]);
	assign p6 = sext16(cfg.press_b[31:16]);

	assign tmp_c  = asr((fine << 2) + fine + 32'd128, 5'd8);
	assign q      = asr(a_s1, 5'd2);
	assign pn_pre = (32'd1048576 - {12'b0, p_s5}) - b12_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (adv) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{v_in, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1   <= tmp_c[17:0];
			a_s1   <= asr(fine, 5'd1) - 32'd64000;
			p_s1   <= adc_p;

			sq_s2  <= q * q;
			ap5_s2 <= a_s1 * p5;
			p2a_s2 <= p2 * a_s1;
			t_s2   <= t_s1;
			p_s2   <= p_s1;

			b1_s3  <= asr(sq_s2, 5'd11) * p6;
			c3_s3  <= p3 * asr(sq_s2, 5'd13);
			ap5_s3 <= ap5_s2;
			p2a_s3 <= p2a_s2;
			t_s3   <= t_s2;
			p_s3   <= p_s2;

			b_s4   <= asr(b1_s3 + (ap5_s3 << 1), 5'd2) + (p4 << 16);
			a2_s4  <= asr(asr(c3_s3, 5'd3) + asr(p2a_s3, 5'd1), 5'd18);
			t_s4   <= t_s3;
			p_s4   <= p_s3;

			m_s5   <= (32'd32768 + a2_s4) * p1;
			b12_s5 <= asr(b_s4, 5'd12);
			t_s5   <= t_s4;
			p_s5   <= p_s4;

			div_s6 <= asr(m_s5, 5'd15);
			pn_s6  <= pn_pre * 32'd3125;
			t_s6   <= t_s5;

			// dividends at or above 2^31 are divided first and doubled after
			big_s7  <= pn_s6[31];
			num_s7  <= pn_s6[31] ? pn_s6 : (pn_s6 << 1);
			div_s7  <= div_s6;
			zero_s7 <= (div_s6 == 32'd0);
			t_s7    <= t_s6;
		end
	end

	assign v_out    = v_s7;
	assign num      = num_s7;
	assign divisor  = div_s7;
	assign tag.temp = t_s7;
	assign tag.big  = big_s7;
	assign tag.zero = zero_s7;
endmodule
`default_nettype wire

@@ rtl/btpc_div.sv @@
`default_nettype none
`include "barometer_temp_pressure_compensation_unit_defines.svh"
module btpc_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                v_in,
	input  wire logic [31:0]         num,
	input  wire logic [31:0]         divisor,
	input  wire btpc_pkg::tag_t      tag_in,
	output logic                     v_out,
	output logic [31:0]              quot,
	output btpc_pkg::tag_t           tag_out
);
	import btpc_pkg::*;

	// one quotient bit per stage, restoring division
	logic        v_s   [1:DivBits];
	logic [31:0] rem_s [1:DivBits];
	logic [31:0] num_s [1:DivBits];
	logic [31:0] div_s [1:DivBits];
	tag_t        tag_s [1:DivBits];

	for (genvar i = 0; i < DivBits; i++) begin : g_stage
		logic        cv;
		logic [31:0] crem, cnum, cdiv;
		tag_t        ctag;
		logic [32:0] trial, diff;
		logic        ge;

		if (i == 0) begin : g_first
			assign cv   = v_in;
			assign crem = '0;
			assign cnum = num;
			assign cdiv = divisor;
			assign ctag = tag_in;
		end else begin : g_next
			assign cv   = v_s[i];
			assign crem = rem_s[i];
			assign cnum = num_s[i];
			assign cdiv = div_s[i];
			assign ctag = tag_s[i];
		end

		assign trial = {crem, cnum[31]};
		assign ge    = trial >= {1'b0, cdiv};
		assign diff  = trial - {1'b0, cdiv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? diff[31:0] : trial[31:0];
				num_s[i+1] <= {cnum[30:0], ge};
				div_s[i+1] <= cdiv;
				tag_s[i+1] <= ctag;
			end
		end
	end

	assign v_out   = v_s[DivBits];
	assign quot    = num_s[DivBits];
	assign tag_out = tag_s[DivBits];

	`BTPC_ASSERT(a_rem_below_div, v_s[DivBits] && div_s[DivBits] != 32'd0 |-> rem_s[DivBits] < div_s[DivBits], "btpc_div: remainder not below divisor")
	`BTPC_ASSERT_HOLD(a_hold_on_stall, !adv, num_s[DivBits], "btpc_div: quotient moved while held")
	`BTPC_ASSERT(a_valid_moves, adv && v_s[DivBits-1] |=> v_s[DivBits], "btpc_div: valid lost in last stage")
endmodule
`default_nettype wire

@@ rtl/btpc_corr.sv @@
`default_nettype none
module btpc_corr (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                v_in,
	input  wire logic [31:0]         quot,
	input  wire btpc_pkg::tag_t      tag_in,
	input  wire btpc_pkg::cfg_t      cfg,
	output logic                     v_out,
	output logic [17:0]              temp,
	output logic [31:0]              press,
	output logic                     zero
);
	import btpc_pkg::*;

	logic [31:0] p7, p8, p9, s;
	logic        v_s1, v_s2, v_s3, v_s4;
	tag_t        g_s1, g_s2, g_s3;
	logic [31:0] p_s1, p_s2, p_s3, sq_s2, b_s2, b_s3, a_s3, press_s4;
	logic [17:0] temp_s4;
	logic        zero_s4;
	logic [31:0] pb_m;

	assign p7   = sext16(cfg.press_b[47:32]);
	assign p8   = sext16(cfg.press_b[63:48]);
	assign p9   = sext16(cfg.press_last);
	assign s    = p_s1 >> 3;
	assign pb_m = (p_s1 >> 2) * p8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4} <= '0;
		end else if (adv) begin
			{v_s1, v_s2, v_s3, v_s4} <= {v_in, v_s1, v_s2, v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= tag_in.big ? (quot << 1) : quot;
			g_s1 <= tag_in;

			sq_s2 <= (s * s) >> 13;
			b_s2  <= asr(pb_m, 5'd13);
			p_s2  <= p_s1;
			g_s2  <= g_s1;

			a_s3 <= asr(p9 * sq_s2, 5'd12);
			b_s3 <= b_s2;
			p_s3 <= p_s2;
			g_s3 <= g_s2;

			press_s4 <= g_s3.zero ? 32'd0 : p_s3 + asr(a_s3 + b_s3 + p7, 5'd4);
			temp_s4  <= g_s3.temp;
			zero_s4  <= g_s3.zero;
		end
	end

	assign v_out = v_s4;
	assign temp  = temp_s4;
	assign press = press_s4;
	assign zero  = zero_s4;
endmodule
`default_nettype wire
